FILE: hw/rtl/grbs_pkg.sv
// shared types, widths and codes for the group-by row sum block
package grbs_pkg;

  // field widths of the stream beats
  localparam int KIND_W   = 1;
  localparam int LABEL_W  = 32;
  localparam int COL_W    = 6;
  localparam int VAL_W    = 32;
  localparam int RGRP_W   = 6;
  localparam int GIDX_W   = 6;
  localparam int SUM_W    = 48;
  localparam int USED_W   = 7;
  localparam int STATUS_W = 2;

  // configuration register
  localparam int                CFG_W     = 7;
  localparam logic [CFG_W-1:0]  CFG_RESET = 7'd64;

  // default sizing
  localparam int MAX_GROUPS_DEF  = 64;
  localparam int MAX_COLUMNS_DEF = 64;
  localparam int LABEL_BITS_DEF  = 32;

  // item kinds
  localparam logic KIND_ACC  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_COL  = 2'd2,
    ST_NO_GROUP = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ACC_RD,
    S_ACC_UPD,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [LABEL_W-1:0]      group_label;
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] element_value;
    logic [RGRP_W-1:0]       read_group;
  } in_item_t;

  typedef struct packed {
    logic [GIDX_W-1:0]       group_index;
    logic signed [SUM_W-1:0] group_sum;
    logic                    new_group;
    logic [USED_W-1:0]       groups_used;
    logic [STATUS_W-1:0]     status;
  } out_item_t;

endpackage

FILE: hw/rtl/grbs_in_if.sv
// valid/ready channel carrying input beats
interface grbs_in_if;
  logic                valid;
  logic                ready;
  grbs_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/grbs_out_if.sv
// valid/ready channel carrying result beats
interface grbs_out_if;
  logic                valid;
  logic                ready;
  grbs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/grbs_ram.sv
// generic single-write, single-read ram with registered read data
module grbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/grbs_sat_add.sv
// saturating adder: 48-bit accumulator plus sign-extended 32-bit element
module grbs_sat_add (
  input  logic signed [grbs_pkg::SUM_W-1:0] acc,
  input  logic signed [grbs_pkg::VAL_W-1:0] val,
  output logic signed [grbs_pkg::SUM_W-1:0] sum
);

  localparam int SW = grbs_pkg::SUM_W;
  localparam int VW = grbs_pkg::VAL_W;

  logic [SW:0] wide;

  assign wide = {acc[SW-1], acc} + {{(SW + 1 - VW){val[VW-1]}}, val};

  always_comb begin
    if (wide[SW] != wide[SW-1]) begin
      // overflow: clamp towards the sign of the true result
      sum = wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum = wide[SW-1:0];
    end
  end

endmodule

FILE: hw/rtl/grbs_ctrl.sv
// sequencer: label scan, group assignment and accumulator read-modify-write
module grbs_ctrl #(
  parameter int MAX_GROUPS  = grbs_pkg::MAX_GROUPS_DEF,
  parameter int MAX_COLUMNS = grbs_pkg::MAX_COLUMNS_DEF,
  parameter int LABEL_BITS  = grbs_pkg::LABEL_BITS_DEF,
  localparam int GW        = $clog2(MAX_GROUPS),
  localparam int LW        = (LABEL_BITS < grbs_pkg::LABEL_W) ? LABEL_BITS : grbs_pkg::LABEL_W,
  localparam int ACC_DEPTH = MAX_GROUPS * MAX_COLUMNS,
  localparam int AW        = $clog2(ACC_DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [grbs_pkg::CFG_W-1:0]        cols_cfg,
  grbs_in_if.sink                           in_bus,
  grbs_out_if.source                        out_bus,
  output logic                              lbl_we,
  output logic [GW-1:0]                     lbl_waddr,
  output logic [LW-1:0]                     lbl_wdata,
  output logic [GW-1:0]                     lbl_raddr,
  input  logic [LW-1:0]                     lbl_rdata,
  output logic                              acc_we,
  output logic [AW-1:0]                     acc_waddr,
  output logic signed [grbs_pkg::SUM_W-1:0] acc_wdata,
  output logic [AW-1:0]                     acc_raddr,
  input  logic signed [grbs_pkg::SUM_W-1:0] acc_rdata
);

  localparam int CNTW  = $clog2(MAX_GROUPS + 1);
  localparam int LIMW  = ($clog2(MAX_COLUMNS + 1) > grbs_pkg::CFG_W) ?
                         $clog2(MAX_COLUMNS + 1) : grbs_pkg::CFG_W;
  localparam int RW    = (CNTW > grbs_pkg::RGRP_W) ? CNTW : grbs_pkg::RGRP_W;

  grbs_pkg::state_t state_r, state_nxt;

  // control
  logic [CNTW-1:0] count_r, count_nxt;
  logic [CNTW-1:0] scan_idx_r, scan_idx_nxt;
  logic            chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic            out_valid_r, out_valid_nxt;

  // payload
  logic                              kind_r, kind_nxt;
  logic [LW-1:0]                     label_r, label_nxt;
  logic [grbs_pkg::COL_W-1:0]        col_r, col_nxt;
  logic signed [grbs_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [GW-1:0]                     g_r, g_nxt;
  logic [GW-1:0]                     chk_idx_r, chk_idx_nxt;
  logic [grbs_pkg::GIDX_W-1:0]       res_idx_r, res_idx_nxt;
  logic signed [grbs_pkg::SUM_W-1:0] res_sum_r, res_sum_nxt;
  logic                              res_new_r, res_new_nxt;
  grbs_pkg::status_t                 res_st_r, res_st_nxt;
  grbs_pkg::out_item_t               out_data_r, out_data_nxt;

  logic                              col_ok, rg_ok, hit, more, full, out_free;
  logic [AW-1:0]                     acc_addr;
  logic signed [grbs_pkg::SUM_W-1:0] sat_sum;

  assign in_bus.ready  = (state_r == grbs_pkg::S_IDLE);
  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;

  // column limit is min(columns_in_use, MAX_COLUMNS)
  assign col_ok = (LIMW'(in_bus.data.column) < LIMW'(cols_cfg)) &&
                  (LIMW'(in_bus.data.column) < LIMW'(MAX_COLUMNS));
  assign rg_ok  = RW'(in_bus.data.read_group) < RW'(count_r);

  assign hit      = chk_vld_r && (lbl_rdata == label_r);
  assign more     = scan_idx_r < count_r;
  assign full     = (count_r == CNTW'(MAX_GROUPS));
  assign out_free = !out_valid_r || out_bus.ready;

  assign acc_addr  = AW'(g_r) * AW'(MAX_COLUMNS) + AW'(col_r);
  assign acc_raddr = acc_addr;
  assign lbl_raddr = scan_idx_r[GW-1:0];

  grbs_sat_add u_sat_add (
    .acc (acc_rdata),
    .val (val_r),
    .sum (sat_sum)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      grbs_pkg::S_CLEAR: begin
        if (clr_addr_r == AW'(ACC_DEPTH - 1)) begin
          state_nxt = grbs_pkg::S_IDLE;
        end
      end
      grbs_pkg::S_IDLE: begin
        if (in_bus.valid) begin
          if (in_bus.data.kind == grbs_pkg::KIND_READ) begin
            state_nxt = (col_ok && rg_ok) ? grbs_pkg::S_ACC_RD : grbs_pkg::S_FINISH;
          end else begin
            state_nxt = col_ok ? grbs_pkg::S_SCAN : grbs_pkg::S_FINISH;
          end
        end
      end
      grbs_pkg::S_SCAN: begin
        priority if (hit) begin
          state_nxt = grbs_pkg::S_ACC_RD;
        end else if (more) begin
          state_nxt = grbs_pkg::S_SCAN;
        end else begin
          state_nxt = full ? grbs_pkg::S_FINISH : grbs_pkg::S_ACC_RD;
        end
      end
      grbs_pkg::S_ACC_RD:  state_nxt = grbs_pkg::S_ACC_UPD;
      grbs_pkg::S_ACC_UPD: state_nxt = grbs_pkg::S_FINISH;
      grbs_pkg::S_FINISH: begin
        if (out_free) begin
          state_nxt = grbs_pkg::S_IDLE;
        end
      end
      default: state_nxt = grbs_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    count_nxt     = count_r;
    scan_idx_nxt  = scan_idx_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    label_nxt     = label_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    g_nxt         = g_r;
    res_idx_nxt   = res_idx_r;
    res_sum_nxt   = res_sum_r;
    res_new_nxt   = res_new_r;
    res_st_nxt    = res_st_r;
    out_data_nxt  = out_data_r;
    lbl_we        = 1'b0;
    lbl_waddr     = count_r[GW-1:0];
    lbl_wdata     = label_r;
    acc_we        = 1'b0;
    acc_waddr     = acc_addr;
    acc_wdata     = sat_sum;

    if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      grbs_pkg::S_CLEAR: begin
        acc_we       = 1'b1;
        acc_waddr    = clr_addr_r;
        acc_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      grbs_pkg::S_IDLE: begin
        if (in_bus.valid) begin
          kind_nxt     = in_bus.data.kind;
          label_nxt    = in_bus.data.group_label[LW-1:0];
          col_nxt      = in_bus.data.column;
          val_nxt      = in_bus.data.element_value;
          res_new_nxt  = 1'b0;
          res_sum_nxt  = '0;
          res_st_nxt   = grbs_pkg::ST_OK;
          scan_idx_nxt = '0;
          chk_vld_nxt  = 1'b0;
          if (in_bus.data.kind == grbs_pkg::KIND_READ) begin
            res_idx_nxt = in_bus.data.read_group;
            g_nxt       = GW'(in_bus.data.read_group);
            priority if (!col_ok) begin
              res_st_nxt = grbs_pkg::ST_BAD_COL;
            end else if (!rg_ok) begin
              res_st_nxt = grbs_pkg::ST_NO_GROUP;
            end else begin
              res_st_nxt = grbs_pkg::ST_OK;
            end
          end else begin
            res_idx_nxt = '0;
            if (!col_ok) begin
              res_st_nxt = grbs_pkg::ST_BAD_COL;
            end
          end
        end
      end
      grbs_pkg::S_SCAN: begin
        // one label read issued per beat, compared in the beat after, from the registered read data
        priority if (hit) begin
          g_nxt = chk_idx_r;
        end else if (more) begin
          chk_vld_nxt  = 1'b1;
          chk_idx_nxt  = scan_idx_r[GW-1:0];
          scan_idx_nxt = scan_idx_r + CNTW'(1);
        end else if (full) begin
          res_st_nxt = grbs_pkg::ST_FULL;
        end else begin
          lbl_we      = 1'b1;
          g_nxt       = count_r[GW-1:0];
          res_new_nxt = 1'b1;
          count_nxt   = count_r + CNTW'(1);
        end
      end
      grbs_pkg::S_ACC_RD: begin
        // read address is issued from g_r and col_r
      end
      grbs_pkg::S_ACC_UPD: begin
        res_idx_nxt = grbs_pkg::GIDX_W'(g_r);
        if (kind_r == grbs_pkg::KIND_READ) begin
          res_sum_nxt = acc_rdata;
        end else begin
          res_sum_nxt = sat_sum;
          acc_we      = 1'b1;
        end
      end
      grbs_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.group_index = res_idx_r;
          out_data_nxt.group_sum   = res_sum_r;
          out_data_nxt.new_group   = res_new_r;
          out_data_nxt.groups_used = grbs_pkg::USED_W'(count_r);
          out_data_nxt.status      = res_st_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grbs_pkg::S_CLEAR;
      count_r     <= '0;
      scan_idx_r  <= '0;
      chk_vld_r   <= 1'b0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_idx_r  <= scan_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    label_r    <= label_nxt;
    col_r      <= col_nxt;
    val_r      <= val_nxt;
    g_r        <= g_nxt;
    chk_idx_r  <= chk_idx_nxt;
    res_idx_r  <= res_idx_nxt;
    res_sum_r  <= res_sum_nxt;
    res_new_r  <= res_new_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: hw/rtl/group_by_row_sum_core.sv
// top level: streaming group-by sum with label table and accumulator store
// accumulate beat: label scan of one table entry per cycle over the N groups in
//   use at accept, then S_ACC_RD, S_ACC_UPD and S_FINISH (S_FINISH alone if full)
// read beat: S_ACC_RD, S_ACC_UPD, S_FINISH; rejected beat: S_FINISH; then S_IDLE
// reset: groups and column limit reset, then a clearing pass over all
//   MAX_GROUPS * MAX_COLUMNS entries zeroes the accumulators before in_bus.ready
module group_by_row_sum_core #(
  parameter int MAX_GROUPS  = grbs_pkg::MAX_GROUPS_DEF,
  parameter int MAX_COLUMNS = grbs_pkg::MAX_COLUMNS_DEF,
  parameter int LABEL_BITS  = grbs_pkg::LABEL_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [grbs_pkg::CFG_W-1:0] cfg_wdata,
  grbs_in_if.sink                    in_bus,
  grbs_out_if.source                 out_bus
);

  localparam int GW        = $clog2(MAX_GROUPS);
  localparam int LW        = (LABEL_BITS < grbs_pkg::LABEL_W) ? LABEL_BITS : grbs_pkg::LABEL_W;
  localparam int ACC_DEPTH = MAX_GROUPS * MAX_COLUMNS;
  localparam int AW        = $clog2(ACC_DEPTH);

  logic [grbs_pkg::CFG_W-1:0]        cols_r;

  logic                              lbl_we;
  logic [GW-1:0]                     lbl_waddr;
  logic [LW-1:0]                     lbl_wdata;
  logic [GW-1:0]                     lbl_raddr;
  logic [LW-1:0]                     lbl_rdata;
  logic                              acc_we;
  logic [AW-1:0]                     acc_waddr;
  logic signed [grbs_pkg::SUM_W-1:0] acc_wdata;
  logic [AW-1:0]                     acc_raddr;
  logic signed [grbs_pkg::SUM_W-1:0] acc_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= grbs_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cols_r <= cfg_wdata;
    end
  end

  grbs_ctrl #(
    .MAX_GROUPS  (MAX_GROUPS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .LABEL_BITS  (LABEL_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cols_cfg  (cols_r),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .lbl_we    (lbl_we),
    .lbl_waddr (lbl_waddr),
    .lbl_wdata (lbl_wdata),
    .lbl_raddr (lbl_raddr),
    .lbl_rdata (lbl_rdata),
    .acc_we    (acc_we),
    .acc_waddr (acc_waddr),
    .acc_wdata (acc_wdata),
    .acc_raddr (acc_raddr),
    .acc_rdata (acc_rdata)
  );

  grbs_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_GROUPS)
  ) u_label_ram (
    .clk   (clk),
    .we    (lbl_we),
    .waddr (lbl_waddr),
    .wdata (lbl_wdata),
    .raddr (lbl_raddr),
    .rdata (lbl_rdata)
  );

  grbs_ram #(
    .WIDTH (grbs_pkg::SUM_W),
    .DEPTH (ACC_DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  // accumulator store is never written in the beat an item is taken
  a_no_acc_write_on_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |-> !acc_we
  ) else $error("accumulator write while accepting a beat");

  // a new group is always followed by its accumulate, never by another assignment
  a_label_write_single: assert property (
    @(posedge clk) disable iff (!rst_n)
    lbl_we |=> !lbl_we
  ) else $error("back-to-back label table writes");

  // a result is only loaded while the input side is closed
  a_result_while_busy: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_bus.valid) |-> $past(!in_bus.ready)
  ) else $error("result loaded while input side open");

endmodule
